@@ hdl/ksbs_pkg.sv @@
// Shared types and constants for the knapsack best-subset block.
// Used by ksbs_ctrl, ksbs_dpath and knapsack_best_subset_top; depends on nothing.
package ksbs_pkg;

   localparam int MAX_ITEMS    = 32;
   localparam int MAX_CAPACITY = 1024;

   localparam int ITEM_AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int ITEM_CW  = $clog2(MAX_ITEMS + 1);
   localparam int CAP_AW   = $clog2(MAX_CAPACITY);

   localparam int DEPTH_W  = 10;
   localparam int GOLD_W   = 16;
   localparam int WEIGHT_W = 22;
   localparam int VALUE_W  = 21;
   localparam int CFG_W    = 10;
   localparam int KIND_W   = 2;
   localparam int CSR_IW   = 2;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_CAPACITY     = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_DESCENT_RATE = 2'd1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BEST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COUNT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ITEM  = 2'd2;

   typedef struct packed {
      logic [DEPTH_W-1:0] item_depth;
      logic [GOLD_W-1:0]  item_gold;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [VALUE_W-1:0] amount;
      logic [DEPTH_W-1:0] chosen_depth;
      logic [GOLD_W-1:0]  chosen_gold;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth;
      logic [GOLD_W-1:0]   gold;
      logic [WEIGHT_W-1:0] weight;
   } item_rec_type;

   // controller to datapath
   typedef struct packed {
      logic              load_item;
      logic              clr_item_cnt;
      logic              idx_first;
      logic              idx_last;
      logic              idx_inc;
      logic              idx_dec;
      logic              j_set_cap;
      logic              j_dec;
      logic              clr_wr;
      logic              item_rd;
      logic              dp_rd;
      logic              best_rd;
      logic              rc_rd;
      logic              rc_eval;
      logic              clr_sel;
      logic              cnt_dec;
      logic              out_load;
      logic [KIND_W-1:0] out_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_at_n;
      logic idx_zero;
      logic sel_bit;
      logic cnt_zero;
      logic cnt_one;
      logic rsp_free;
      logic w_over_cap;
      logic j_at_w;
      logic j_zero;
   } stat_type;

endpackage

@@ hdl/knapsack_best_subset_top.sv @@
// Top level of the knapsack best-subset block: joins controller and datapath.
// Depends on ksbs_pkg, ksbs_ctrl and ksbs_dpath.
//
// Items of a data set are taken one per cycle until the item marked last.
// The block then clears the value table over capacities 0..cap. It runs one
// table pass per stored item: it fetches the item, then updates capacities
// from cap down to the item's weight, one capacity entry per cycle through the
// value table's write port. An item heavier than cap is skipped after the
// fetch. It then emits the best total, traces the chosen set back from the
// last item to the first, and emits the chosen count and the chosen items in
// arrival order, found by a scan over item indexes up to the last chosen one.
// A stall at the output holds each result until the output register is free.
// No new item is taken until the last result has been handed to the output
// register.
module knapsack_best_subset_top import ksbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   ksbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_item),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ksbs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ hdl/ksbs_ctrl.sv @@
// Sequencer for the knapsack best-subset block: load, clear, table fill,
// traceback and result emission. Depends on ksbs_pkg.
module ksbs_ctrl import ksbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_last,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_LOAD     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_DP_FETCH = 4'd2;
   localparam logic [3:0] S_DP_CHECK = 4'd3;
   localparam logic [3:0] S_DP_RUN   = 4'd4;
   localparam logic [3:0] S_BEST_RD  = 4'd5;
   localparam logic [3:0] S_BEST_OUT = 4'd6;
   localparam logic [3:0] S_RC_RD    = 4'd7;
   localparam logic [3:0] S_RC_EVAL  = 4'd8;
   localparam logic [3:0] S_CNT_OUT  = 4'd9;
   localparam logic [3:0] S_EM_SCAN  = 4'd10;
   localparam logic [3:0] S_EM_OUT   = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (req_last) begin
                  cmd.j_set_cap = 1'b1;
                  state_in      = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.j_zero) begin
               cmd.idx_first = 1'b1;
               state_in      = S_DP_FETCH;
            end else begin
               cmd.j_dec = 1'b1;
            end
         end
         S_DP_FETCH: begin
            if (stat.idx_at_n) begin
               state_in = S_BEST_RD;
            end else begin
               cmd.item_rd = 1'b1;
               state_in    = S_DP_CHECK;
            end
         end
         S_DP_CHECK: begin
            // skip an item that cannot fit at all
            if (stat.w_over_cap) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DP_FETCH;
            end else begin
               cmd.j_set_cap = 1'b1;
               state_in      = S_DP_RUN;
            end
         end
         S_DP_RUN: begin
            cmd.dp_rd = 1'b1;
            if (stat.j_at_w) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DP_FETCH;
            end else begin
               cmd.j_dec = 1'b1;
            end
         end
         S_BEST_RD: begin
            cmd.best_rd = 1'b1;
            state_in    = S_BEST_OUT;
         end
         S_BEST_OUT: begin
            if (stat.rsp_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_BEST;
               cmd.j_set_cap = 1'b1;
               cmd.idx_last  = 1'b1;
               cmd.clr_sel   = 1'b1;
               state_in      = S_RC_RD;
            end
         end
         S_RC_RD: begin
            cmd.rc_rd   = 1'b1;
            cmd.item_rd = 1'b1;
            state_in    = S_RC_EVAL;
         end
         S_RC_EVAL: begin
            cmd.rc_eval = 1'b1;
            if (stat.idx_zero) begin
               state_in = S_CNT_OUT;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = S_RC_RD;
            end
         end
         S_CNT_OUT: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_COUNT;
               if (stat.cnt_zero) begin
                  cmd.clr_item_cnt = 1'b1;
                  state_in         = S_LOAD;
               end else begin
                  cmd.idx_first = 1'b1;
                  state_in      = S_EM_SCAN;
               end
            end
         end
         S_EM_SCAN: begin
            if (stat.sel_bit) begin
               cmd.item_rd = 1'b1;
               state_in    = S_EM_OUT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_EM_OUT: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_ITEM;
               cmd.cnt_dec  = 1'b1;
               if (stat.cnt_one) begin
                  cmd.clr_item_cnt = 1'b1;
                  state_in         = S_LOAD;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_EM_SCAN;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/ksbs_dpath.sv @@
// Datapath of the knapsack best-subset block: settings, item store, value
// table, take marks, traceback counters and the result register. Depends on ksbs_pkg.
module ksbs_dpath import ksbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  req_type           req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  cmd_type           cmd,
   output stat_type          stat
);

   logic [CFG_W-1:0]   capacity_ff, capacity_in;
   logic [CFG_W-1:0]   rate_ff, rate_in;
   logic [ITEM_CW-1:0] item_count_ff, item_count_in;
   logic [ITEM_CW-1:0] idx_ff, idx_in;
   logic [CAP_AW-1:0]  j_ff, j_in;
   logic [MAX_ITEMS-1:0] sel_ff, sel_in;
   logic [ITEM_CW-1:0] sel_cnt_ff, sel_cnt_in;
   logic               dp_vld_ff;
   logic [CAP_AW-1:0]  dp_j_ff;
   logic [ITEM_AW-1:0] dp_idx_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_in;

   logic [CAP_AW-1:0]   cap_sat;
   logic [2*CFG_W-1:0]  prod;
   item_rec_type        new_rec;
   item_rec_type        item_q_ff;
   logic [VALUE_W-1:0]  hi_ff, lo_ff;
   logic                mark_q_ff;
   logic [VALUE_W:0]    cand;
   logic                better;
   logic                take;
   logic [WEIGHT_W-1:0] j_wide;
   logic [ITEM_AW-1:0]  idx_a;

   logic                bv_we;
   logic [CAP_AW-1:0]   bv_wa, bv_ra_hi, bv_ra_lo;
   logic [VALUE_W-1:0]  bv_wd;

   item_rec_type       item_mem [MAX_ITEMS];
   logic [VALUE_W-1:0] bv_mem   [MAX_CAPACITY];
   logic               mark_mem [MAX_ITEMS*MAX_CAPACITY];

   assign idx_a   = idx_ff[ITEM_AW-1:0];
   assign cap_sat = (32'(capacity_ff) > 32'(MAX_CAPACITY - 1)) ?
                    CAP_AW'(MAX_CAPACITY - 1) : CAP_AW'(capacity_ff);
   assign j_wide  = WEIGHT_W'(j_ff);

   // weight = 3 * rate * depth
   assign prod = (2*CFG_W)'(rate_ff) * (2*CFG_W)'(req_data.item_depth);
   always_comb begin
      new_rec.depth  = req_data.item_depth;
      new_rec.gold   = req_data.item_gold;
      new_rec.weight = WEIGHT_W'(prod) + WEIGHT_W'({prod, 1'b0});
   end

   // settings
   always_comb begin
      capacity_in = capacity_ff;
      rate_in     = rate_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY:     capacity_in = csr_wdata;
            CSR_DESCENT_RATE: rate_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // table fill compare on registered reads
   assign cand   = (VALUE_W+1)'(lo_ff) + (VALUE_W+1)'(item_q_ff.gold);
   assign better = cand > (VALUE_W+1)'(hi_ff);
   assign take   = mark_q_ff && (item_q_ff.weight <= j_wide);

   // counters and traceback state
   always_comb begin
      item_count_in = item_count_ff;
      if (cmd.clr_item_cnt) begin
         item_count_in = '0;
      end else if (cmd.load_item && (item_count_ff < ITEM_CW'(MAX_ITEMS))) begin
         item_count_in = item_count_ff + 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.idx_first) begin
         idx_in = '0;
      end else if (cmd.idx_last) begin
         idx_in = item_count_ff - 1'b1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end

      j_in = j_ff;
      if (cmd.j_set_cap) begin
         j_in = cap_sat;
      end else if (cmd.j_dec) begin
         j_in = j_ff - 1'b1;
      end else if (cmd.rc_eval && take) begin
         j_in = j_ff - item_q_ff.weight[CAP_AW-1:0];
      end

      sel_in     = sel_ff;
      sel_cnt_in = sel_cnt_ff;
      if (cmd.clr_sel) begin
         sel_in     = '0;
         sel_cnt_in = '0;
      end else if (cmd.rc_eval && take) begin
         sel_in[idx_a] = 1'b1;
         sel_cnt_in    = sel_cnt_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         sel_cnt_in = sel_cnt_ff - 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_in             = '0;
      rsp_in.result_kind = cmd.out_kind;
      case (cmd.out_kind)
         KIND_BEST: begin
            rsp_in.amount = hi_ff;
         end
         KIND_COUNT: begin
            rsp_in.amount      = VALUE_W'(sel_cnt_ff);
            rsp_in.last_result = (sel_cnt_ff == '0);
         end
         KIND_ITEM: begin
            rsp_in.chosen_depth = item_q_ff.depth;
            rsp_in.chosen_gold  = item_q_ff.gold;
            rsp_in.last_result  = (sel_cnt_ff == ITEM_CW'(1));
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= '0;
         rate_ff       <= CFG_W'(1);
         item_count_ff <= '0;
         idx_ff        <= '0;
         j_ff          <= '0;
         sel_ff        <= '0;
         sel_cnt_ff    <= '0;
         dp_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         rate_ff       <= rate_in;
         item_count_ff <= item_count_in;
         idx_ff        <= idx_in;
         j_ff          <= j_in;
         sel_ff        <= sel_in;
         sel_cnt_ff    <= sel_cnt_in;
         dp_vld_ff     <= cmd.dp_rd;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      // hold the write address of the table step in flight
      dp_j_ff   <= j_ff;
      dp_idx_ff <= idx_a;
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // item store
   always_ff @(posedge clock) begin
      if (cmd.load_item && (item_count_ff < ITEM_CW'(MAX_ITEMS))) begin
         item_mem[item_count_ff[ITEM_AW-1:0]] <= new_rec;
      end
      if (cmd.item_rd) begin
         item_q_ff <= item_mem[idx_a];
      end
   end

   // value table: one write port, two read ports
   assign bv_we    = cmd.clr_wr || (dp_vld_ff && better);
   assign bv_wa    = cmd.clr_wr ? j_ff : dp_j_ff;
   assign bv_wd    = cmd.clr_wr ? '0 : cand[VALUE_W-1:0];
   assign bv_ra_hi = cmd.best_rd ? cap_sat : j_ff;
   assign bv_ra_lo = j_ff - item_q_ff.weight[CAP_AW-1:0];

   always_ff @(posedge clock) begin
      if (bv_we) begin
         bv_mem[bv_wa] <= bv_wd;
      end
      if (cmd.dp_rd || cmd.best_rd) begin
         hi_ff <= bv_mem[bv_ra_hi];
         lo_ff <= bv_mem[bv_ra_lo];
      end
   end

   // take marks: every cell in the scanned range is rewritten each pass
   always_ff @(posedge clock) begin
      if (dp_vld_ff) begin
         mark_mem[{dp_idx_ff, dp_j_ff}] <= better;
      end
      if (cmd.rc_rd) begin
         mark_q_ff <= mark_mem[{idx_a, j_ff}];
      end
   end

   always_comb begin
      stat.idx_at_n   = (idx_ff == item_count_ff);
      stat.idx_zero   = (idx_ff == '0);
      stat.sel_bit    = sel_ff[idx_a];
      stat.cnt_zero   = (sel_cnt_ff == '0);
      stat.cnt_one    = (sel_cnt_ff == ITEM_CW'(1));
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
      stat.w_over_cap = item_q_ff.weight > WEIGHT_W'(cap_sat);
      stat.j_at_w     = (j_wide == item_q_ff.weight);
      stat.j_zero     = (j_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
